>>> hdl/wct_pkg.sv
`timescale 1ns / 1ps

package wct_pkg;

    localparam int unsigned MAX_WINDOWS_DEF   = 1024;
    localparam int unsigned BACKOFF_LIMIT_DEF = 1024;

    localparam int unsigned DIV_W   = 17;
    localparam int unsigned MAP_W   = 64;
    localparam int unsigned IN_TD_W = 168;
    localparam int unsigned OUT_TD_W = 128;

    localparam logic [2:0] F_DATA   = 3'd0;
    localparam logic [2:0] F_STATUS = 3'd1;
    localparam logic [2:0] F_NACK   = 3'd2;
    localparam logic [2:0] F_TICK   = 3'd3;
    localparam logic [2:0] F_END    = 3'd4;

    localparam logic [1:0] K_STORE = 2'd0;
    localparam logic [1:0] K_NACK  = 2'd1;
    localparam logic [1:0] K_END   = 2'd2;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_FILE   = 3'd1;
    localparam logic [2:0] REG_TOTAL  = 3'd2;
    localparam logic [2:0] REG_CPW    = 3'd3;
    localparam logic [2:0] REG_NODE   = 3'd4;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

    // Mask of the lowest n bits, n from 1 to 64.
    function automatic logic [MAP_W-1:0] low_mask(input logic [6:0] n);
        logic [MAP_W-1:0] m;
        if (n >= 7'd64) begin
            m = '1;
        end else begin
            m = (64'd1 << n[5:0]) - 64'd1;
        end
        return m;
    endfunction

endpackage

>>> hdl/wct_divider.sv
`timescale 1ns / 1ps

module wct_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wct_pkg::t_div_req i_req,
    output wct_pkg::t_div_rsp o_rsp
);

    localparam int unsigned W = wct_pkg::DIV_W;

    logic [W-1:0]         r_quo, n_quo;
    logic [W:0]           r_rem, n_rem;
    logic [W-1:0]         r_dvs;
    logic [$clog2(W)-1:0] r_cnt;
    logic                 r_busy, r_done;
    logic [W:0]           w_trial;

    // One quotient bit per cycle, restoring.
    always_comb begin
        w_trial = {r_rem[W-1:0], r_quo[W-1]};
        n_quo   = {r_quo[W-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem    = w_trial - {1'b0, r_dvs};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(W))'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem[W-1:0];

endmodule

>>> hdl/wct_ram.sv
`timescale 1ns / 1ps

module wct_ram #(
    parameter int unsigned DEPTH = wct_pkg::MAX_WINDOWS_DEF,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 65
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/windowed_chunk_tracker_nack_suppress_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat fields
// s_axis    in   tuser: func; tdata: file, chunk, crc, window, round, sender, peer mask, backoff
// m_axis    out  tuser: result kind; tdata: store index, done, nack window/round/mask/count, all
// cfg       in   we, idx, data: one register write per cycle with we high
//
// After reset the window memory is cleared row by row before the first beat is taken.
// A matched data beat holds the input while the 17-step divider runs, then the memory read,
// check and write; a status request while the window check, memory read, backoff remainder
// by reciprocal multiply, then 8 popcount steps run. NACK beats are taken in S_IDLE alone;
// tick and end beats pass S_EMIT only when they produce a result. A result waits in the output
// register while m_axis is stalled, and no new beat is taken until it has been loaded there.
module windowed_chunk_tracker_nack_suppress_unit #(
    parameter int unsigned MAX_WINDOWS   = wct_pkg::MAX_WINDOWS_DEF,
    parameter int unsigned BACKOFF_LIMIT = wct_pkg::BACKOFF_LIMIT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // file[31:0] chunk_index[47:32] crc_good[48] window_index[64:49] round_number[80:65]
    // sender_node[88:81] peer_missing[152:89] backoff_ticks[162:153]
    input  logic [167:0] s_axis_tdata,
    // func[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // store_index[15:0] window_done[16] nack_window[32:17] nack_round[48:33]
    // nack_mask[112:49] nack_count[119:113] all_arrived[120]
    output logic [127:0] m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]   m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);

    localparam int unsigned AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam logic [16:0] MW17 = 17'(MAX_WINDOWS);
    localparam logic [16:0] BL17 = 17'(BACKOFF_LIMIT);
    localparam logic [AW-1:0] LAST_ROW = AW'(MAX_WINDOWS - 1);
    // Reciprocal of the backoff limit, exact for every 10-bit backoff.
    localparam logic [20:0] BO_RECIP =
        21'(((64'd1 << 20) + 64'(BACKOFF_LIMIT) - 64'd1) / 64'(BACKOFF_LIMIT));

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DDIV, S_DRD, S_DCHK, S_DWR,
        S_SMUL, S_SCHK, S_SRD, S_SMISS, S_SDIV, S_POP, S_EMIT
    } t_state;

    t_state r_state;

    // Configuration.
    logic        r_en;
    logic [31:0] r_file;
    logic [16:0] r_total;
    logic [6:0]  r_cpw;
    logic [7:0]  r_node;

    // Latched beat.
    logic [15:0] r_cidx, r_rnd;
    logic [9:0]  r_bo_in;

    // Working registers.
    logic [AW-1:0] r_clr;
    logic [15:0]   r_win;
    logic [5:0]    r_bitpos;
    logic [22:0]   r_prod;
    logic [6:0]    r_n;
    logic [63:0]   r_map;
    logic          r_oldc;
    logic [63:0]   r_miss;
    logic [63:0]   r_pop_sh;
    logic [6:0]    r_pop_acc;
    logic [2:0]    r_pop_step;
    logic [9:0]    r_bo;
    logic [9:0]    r_bo_q;
    logic          r_div_go;
    logic [16:0]   r_div_a, r_div_b;

    // Pending NACK.
    logic        r_pend_active, r_pend_supp;
    logic [15:0] r_pend_win, r_pend_rnd;
    logic [63:0] r_pend_mask;
    logic [9:0]  r_pend_cd;
    logic [6:0]  r_pend_count;

    logic [16:0] r_total_rx;

    // Result staging and output.
    logic [1:0]   r_res_kind;
    logic [127:0] r_res_data;
    logic         r_m_valid;
    logic [127:0] r_m_data;
    logic [1:0]   r_m_kind;

    // Memory: bit 64 holds the complete flag, bits 63:0 the received bitmap.
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [64:0]   w_wdata;
    logic [64:0]   w_rdata;

    wct_pkg::t_div_req w_req;
    wct_pkg::t_div_rsp w_rsp;

    logic [6:0]  w_c;
    logic        w_matched;
    logic        w_acc;
    logic [2:0]  w_func;
    logic [16:0] w_left;
    logic [6:0]  w_n;
    logic [63:0] w_exp;
    logic [63:0] w_miss;
    logic [3:0]  w_byte_ones;
    logic [30:0] w_bo_prod;
    logic [26:0] w_bo_qbl;

    assign w_func = s_axis_tuser;
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_matched = r_en && (s_axis_tdata[31:0] == r_file);

    always_comb begin
        if (r_cpw == 7'd0) begin
            w_c = 7'd1;
        end else if (r_cpw > 7'd64) begin
            w_c = 7'd64;
        end else begin
            w_c = r_cpw;
        end
    end

    // Chunks in window r_win: the remainder of the file, at most one full window.
    assign w_left = r_total - r_prod[16:0];
    assign w_n    = (w_left > {10'd0, w_c}) ? w_c : w_left[6:0];
    assign w_exp  = wct_pkg::low_mask(r_n);
    assign w_miss = w_exp & ~w_rdata[63:0];

    // Backoff remainder: quotient by reciprocal, then one multiply back and subtract.
    assign w_bo_prod = 31'(r_bo_in) * 31'(BO_RECIP);
    assign w_bo_qbl  = 27'(r_bo_q) * 27'(BL17);

    always_comb begin
        w_byte_ones = '0;
        for (int i = 0; i < 8; i++) begin
            w_byte_ones = w_byte_ones + {3'd0, r_pop_sh[i]};
        end
    end

    assign w_req.start    = r_div_go;
    assign w_req.dividend = r_div_a;
    assign w_req.divisor  = r_div_b;

    wct_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_win[AW-1:0];
        w_wdata = {r_oldc || (r_map == w_exp), r_map};
        if (r_state == S_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_state == S_DWR) begin
            w_we = 1'b1;
        end
    end

    wct_ram #(
        .DEPTH (MAX_WINDOWS),
        .AW    (AW),
        .DW    (65)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_win[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en          <= 1'b0;
            r_file        <= '0;
            r_total       <= '0;
            r_cpw         <= 7'd64;
            r_node        <= '0;
            r_state       <= S_CLR;
            r_clr         <= '0;
            r_win         <= '0;
            r_div_go      <= 1'b0;
            r_pend_active <= 1'b0;
            r_pend_supp   <= 1'b0;
            r_pend_win    <= '0;
            r_pend_rnd    <= '0;
            r_pend_mask   <= '0;
            r_pend_cd     <= '0;
            r_pend_count  <= '0;
            r_total_rx    <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    wct_pkg::REG_ENABLE: r_en    <= i_cfg_data[0];
                    wct_pkg::REG_FILE:   r_file  <= i_cfg_data;
                    wct_pkg::REG_TOTAL:  r_total <= i_cfg_data[16:0];
                    wct_pkg::REG_CPW:    r_cpw   <= i_cfg_data[6:0];
                    wct_pkg::REG_NODE:   r_node  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // In S_EMIT the output register is reloaded instead.
            if (r_m_valid && m_axis_tready && (r_state != S_EMIT)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_ROW) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_cidx    <= s_axis_tdata[47:32];
                        r_rnd     <= s_axis_tdata[80:65];
                        r_bo_in   <= s_axis_tdata[162:153];
                        unique case (w_func)
                            wct_pkg::F_DATA: begin
                                if (w_matched && ({1'b0, s_axis_tdata[47:32]} < r_total)
                                    && s_axis_tdata[48]) begin
                                    r_div_go <= 1'b1;
                                    r_div_a  <= {1'b0, s_axis_tdata[47:32]};
                                    r_div_b  <= {10'd0, w_c};
                                    r_state  <= S_DDIV;
                                end
                            end
                            wct_pkg::F_STATUS: begin
                                if (w_matched) begin
                                    r_win   <= s_axis_tdata[64:49];
                                    r_state <= S_SMUL;
                                end
                            end
                            wct_pkg::F_NACK: begin
                                if (w_matched && (s_axis_tdata[88:81] != r_node)
                                    && r_pend_active
                                    && (r_pend_win == s_axis_tdata[64:49])
                                    && (r_pend_rnd == s_axis_tdata[80:65])
                                    && ((s_axis_tdata[152:89] & r_pend_mask) == r_pend_mask))
                                begin
                                    r_pend_supp <= 1'b1;
                                end
                            end
                            wct_pkg::F_TICK: begin
                                if (r_pend_active) begin
                                    if (r_pend_cd != 10'd0) begin
                                        r_pend_cd <= r_pend_cd - 1'b1;
                                    end else begin
                                        r_pend_active <= 1'b0;
                                        if (!r_pend_supp) begin
                                            r_res_kind <= wct_pkg::K_NACK;
                                            r_res_data <= {7'd0, 1'b0, r_pend_count,
                                                r_pend_mask, r_pend_rnd, r_pend_win,
                                                1'b0, 16'd0};
                                            r_state <= S_EMIT;
                                        end
                                    end
                                end
                            end
                            wct_pkg::F_END: begin
                                if (w_matched) begin
                                    r_res_kind <= wct_pkg::K_END;
                                    r_res_data <= {7'd0, (r_total_rx == r_total), 120'd0};
                                    r_state    <= S_EMIT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DDIV: begin
                    r_div_go <= 1'b0;
                    if (w_rsp.done) begin
                        if (w_rsp.quot >= MW17) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_win    <= w_rsp.quot[15:0];
                            r_bitpos <= w_rsp.rem[5:0];
                            r_state  <= S_DRD;
                        end
                    end
                end
                S_DRD: begin
                    r_prod  <= r_win * w_c;
                    r_state <= S_DCHK;
                end
                S_DCHK: begin
                    if (w_rdata[r_bitpos]) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_map   <= w_rdata[63:0] | (64'd1 << r_bitpos);
                        r_oldc  <= w_rdata[64];
                        r_n     <= w_n;
                        r_state <= S_DWR;
                    end
                end
                S_DWR: begin
                    r_total_rx <= r_total_rx + 1'b1;
                    r_res_kind <= wct_pkg::K_STORE;
                    r_res_data <= {111'd0, (r_map == w_exp), r_cidx};
                    r_state    <= S_EMIT;
                end
                S_SMUL: begin
                    r_prod  <= r_win * w_c;
                    r_state <= S_SCHK;
                end
                S_SCHK: begin
                    if (({1'b0, r_win} >= MW17) || (r_prod >= {6'd0, r_total})) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_n     <= w_n;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    r_state <= S_SMISS;
                end
                S_SMISS: begin
                    if (w_rdata[64] || (w_miss == 64'd0)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_miss  <= w_miss;
                        r_bo_q  <= w_bo_prod[29:20];
                        r_state <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    r_bo       <= r_bo_in - w_bo_qbl[9:0];
                    r_pop_sh   <= r_miss;
                    r_pop_acc  <= '0;
                    r_pop_step <= '0;
                    r_state    <= S_POP;
                end
                S_POP: begin
                    r_pop_sh   <= {8'd0, r_pop_sh[63:8]};
                    r_pop_acc  <= r_pop_acc + {3'd0, w_byte_ones};
                    r_pop_step <= r_pop_step + 1'b1;
                    if (r_pop_step == 3'd7) begin
                        r_pend_active <= 1'b1;
                        r_pend_supp   <= 1'b0;
                        r_pend_win    <= r_win;
                        r_pend_rnd    <= r_rnd;
                        r_pend_mask   <= r_miss;
                        r_pend_cd     <= r_bo;
                        r_pend_count  <= r_pop_acc + {3'd0, w_byte_ones};
                        r_state       <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= r_res_data;
                        r_m_kind  <= r_res_kind;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_kind;

`ifndef SYNTH
    a_pend_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_active |-> (r_pend_count != 7'd0))
        else $error("pending NACK with an empty mask count");

    a_nack_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == wct_pkg::K_NACK)) |-> (m_axis_tdata[112:49] != 64'd0))
        else $error("NACK result with an empty mask");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> (!s_axis_tready && !m_axis_tvalid))
        else $error("beat moved during the clearing pass");
`endif

endmodule
